// ----- src/csfp_pkg.sv -----
// Shared types, constants and CRC-32 helpers for the stream frame packer.
// No dependencies; every other file in src imports this package.
package csfp_pkg;

    localparam int PAYLOAD_BYTES_DEF = 64;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] FRM_MAGIC   = 32'h31534C50;
    localparam int          HDR_WORDS   = 5;
    localparam int          CTYPE_BYTES = 24;
    localparam int          CTYPE_WORDS = CTYPE_BYTES / 4;
    localparam int          END_BYTES   = 8;

    localparam logic [7:0] FT_BEGIN = 8'd1;
    localparam logic [7:0] FT_DATA  = 8'd2;
    localparam logic [7:0] FT_END   = 8'd3;
    localparam logic [7:0] FT_ABORT = 8'd4;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_END   = 2'd2,
        ACT_ABORT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        FK_BEGIN,
        FK_DATA,
        FK_END,
        FK_ABORT
    } frame_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECRC,
        ST_BEGIN,
        ST_DATA,
        ST_END,
        ST_ABORT
    } state_t;

    typedef struct packed {
        logic        take;
        logic        emit;
        frame_kind_t kind;
        logic        ecrc_step;
        logic        item_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic begun;
        logic pend_nz;
        logic pend_full;
        logic pend_last;
        logic fire;
        logic word_last;
        logic ecrc_last;
    } dp_stat_t;

    // One byte through the reflected CRC-32, stored in its final-xored form
    function automatic logic [31:0] crc_add(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return ~c;
    endfunction

    // Content-type text of the begin frame, four bytes a word, first byte low
    function automatic logic [31:0] ctype_word(input logic [2:0] idx);
        logic [31:0] w;
        unique case (idx)
            3'd0:    w = 32'h74786574;
            3'd1:    w = 32'h616C702F;
            3'd2:    w = 32'h633B6E69;
            3'd3:    w = 32'h73726168;
            3'd4:    w = 32'h753D7465;
            3'd5:    w = 32'h382D6674;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] ctype_crc();
        logic [31:0] c;
        logic [31:0] w;
        c = 32'd0;
        for (int k = 0; k < CTYPE_WORDS; k++) begin
            w = ctype_word(3'(k));
            for (int j = 0; j < 4; j++) begin
                c = crc_add(c, w[8*j +: 8]);
            end
        end
        return c;
    endfunction

    localparam logic [31:0] CTYPE_CRC = ctype_crc();

endpackage

// ----- src/csfp_ctrl.sv -----
// Controller state machine for the stream frame packer.
// Depends on csfp_pkg; drives the datapath through ctrl_cmd_t.
module csfp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           action,
    input  csfp_pkg::dp_stat_t   stat,
    output csfp_pkg::ctrl_cmd_t  cmd,
    output logic                 in_stall
);
    import csfp_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    action_t act_reg;
    action_t act_next;
    action_t act_in;
    logic    take;
    logic    frame_done;

    assign act_in     = action_t'(action);
    assign take       = in_valid && (state_reg == ST_IDLE);
    assign frame_done = stat.fire && stat.word_last;
    assign act_next   = take ? act_in : act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            act_reg   <= ACT_START;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (act_in)
                        ACT_START: state_next = ST_IDLE;
                        ACT_DATA:
                        begin
                            if (!stat.begun)
                                state_next = ST_BEGIN;
                            else if (stat.pend_last)
                                state_next = ST_DATA;
                            else
                                state_next = ST_IDLE;
                        end
                        ACT_END:   state_next = ST_ECRC;
                        ACT_ABORT: state_next = ST_ABORT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ECRC:
            begin
                if (stat.ecrc_last)
                begin
                    if (!stat.begun)
                        state_next = ST_BEGIN;
                    else if (stat.pend_nz)
                        state_next = ST_DATA;
                    else
                        state_next = ST_END;
                end
            end
            ST_BEGIN:
            begin
                if (frame_done)
                begin
                    if (act_reg == ACT_END)
                        state_next = stat.pend_nz ? ST_DATA : ST_END;
                    else
                        state_next = stat.pend_full ? ST_DATA : ST_IDLE;
                end
            end
            ST_DATA:
            begin
                if (frame_done)
                    state_next = (act_reg == ACT_END) ? ST_END : ST_IDLE;
            end
            ST_END, ST_ABORT:
            begin
                if (frame_done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.take      = take;
        cmd.ecrc_step = (state_reg == ST_ECRC);
        cmd.item_last = (state_next == ST_IDLE);
        in_stall      = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_BEGIN:
            begin
                cmd.emit = 1'b1;
                cmd.kind = FK_BEGIN;
            end
            ST_DATA:
            begin
                cmd.emit = 1'b1;
                cmd.kind = FK_DATA;
            end
            ST_END:
            begin
                cmd.emit = 1'b1;
                cmd.kind = FK_END;
            end
            ST_ABORT:
            begin
                cmd.emit = 1'b1;
                cmd.kind = FK_ABORT;
            end
            default:
            begin
                cmd.emit = 1'b0;
                cmd.kind = FK_DATA;
            end
        endcase
    end

endmodule

// ----- src/csfp_datapath.sv -----
// Datapath of the stream frame packer: stream state, payload buffer,
// CRC units, frame word builder and output register. Depends on csfp_pkg.
module csfp_datapath #(
    parameter int PAYLOAD_BYTES = csfp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csfp_pkg::ctrl_cmd_t  cmd,
    output csfp_pkg::dp_stat_t   stat,
    input  logic [1:0]           action,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          frame_word,
    output logic [2:0]           valid_bytes,
    output logic                 frame_last,
    output logic                 item_last
);
    import csfp_pkg::*;

    localparam int CNT_W     = $clog2(PAYLOAD_BYTES + 1);
    localparam int ROWS      = (PAYLOAD_BYTES + 3) / 4;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MAX_WORDS = HDR_WORDS + ROWS + CTYPE_WORDS;
    localparam int WC_W      = $clog2(MAX_WORDS + 1);

    // Stream state
    logic [31:0]      nsid_reg, nsid_next;
    logic [31:0]      sid_reg, sid_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      tcrc_reg, tcrc_next;
    logic [31:0]      chunk_reg, chunk_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic             begun_reg, begun_next;
    logic [31:0]      ecrc_reg, ecrc_next;
    logic [2:0]       ecnt_reg, ecnt_next;
    logic [WC_W-1:0]  wcnt_reg, wcnt_next;

    // Output register
    logic             out_valid_reg;
    logic [31:0]      word_reg;
    logic [2:0]       vb_reg;
    logic             flast_reg;
    logic             ilast_reg;

    // Payload buffer, four byte lanes to a row
    logic [31:0]      buf_mem [ROWS];
    logic [31:0]      rd_data_reg;
    logic [ROW_W-1:0] wr_row;
    logic [1:0]       wr_lane;
    logic [ROW_W-1:0] rd_row;
    logic [WC_W-1:0]  rd_idx;
    logic             wr_en;

    action_t          act_in;
    logic             fire;
    logic             frame_done;
    logic [63:0]      end_pl;
    logic [63:0]      end_shift;
    logic [7:0]       ebyte;
    logic [31:0]      nsid_inc;

    // Frame builder
    logic [7:0]       f_type;
    logic [31:0]      f_seq;
    logic [15:0]      f_len;
    logic [31:0]      f_crc;
    logic             hdr;
    logic [WC_W-1:0]  pidx;
    logic [15:0]      p_off;
    logic [15:0]      p_rem;
    logic [31:0]      raw_word;
    logic [31:0]      bld_word;
    logic [2:0]       bld_vb;
    logic             bld_last;

    assign act_in     = action_t'(action);
    assign fire       = !out_valid_reg || !out_stall;
    assign frame_done = cmd.emit && fire && bld_last;
    assign end_pl     = {tcrc_reg, total_reg};
    assign end_shift  = end_pl >> {ecnt_reg, 3'b000};
    assign ebyte      = end_shift[7:0];
    assign nsid_inc   = nsid_reg + 32'd1;

    assign stat.begun     = begun_reg;
    assign stat.pend_nz   = (pend_reg != '0);
    assign stat.pend_full = (pend_reg == CNT_W'(PAYLOAD_BYTES));
    assign stat.pend_last = (pend_reg == CNT_W'(PAYLOAD_BYTES - 1));
    assign stat.fire      = fire;
    assign stat.word_last = bld_last;
    assign stat.ecrc_last = (ecnt_reg == 3'(END_BYTES - 1));

    // Frame descriptor
    always_comb
    begin
        unique case (cmd.kind)
            FK_BEGIN:
            begin
                f_type = FT_BEGIN;
                f_seq  = 32'd0;
                f_len  = 16'(CTYPE_BYTES);
                f_crc  = CTYPE_CRC;
            end
            FK_DATA:
            begin
                f_type = FT_DATA;
                f_seq  = seq_reg + 32'd1;
                f_len  = 16'(pend_reg);
                f_crc  = chunk_reg;
            end
            FK_END:
            begin
                f_type = FT_END;
                f_seq  = seq_reg + 32'd1;
                f_len  = 16'(END_BYTES);
                f_crc  = ecrc_reg;
            end
            default:
            begin
                f_type = FT_ABORT;
                f_seq  = seq_reg + 32'd1;
                f_len  = 16'd0;
                f_crc  = 32'd0;
            end
        endcase
    end

    // Word builder
    always_comb
    begin
        hdr   = (wcnt_reg < WC_W'(HDR_WORDS));
        pidx  = wcnt_reg - WC_W'(HDR_WORDS);
        p_off = 16'({pidx, 2'b00});
        p_rem = f_len - p_off;

        unique case (cmd.kind)
            FK_BEGIN: raw_word = ctype_word(3'(pidx));
            FK_DATA:  raw_word = rd_data_reg;
            FK_END:   raw_word = (pidx == '0) ? total_reg : tcrc_reg;
            default:  raw_word = 32'd0;
        endcase

        if (hdr)
        begin
            bld_vb   = 3'd4;
            bld_last = (wcnt_reg == WC_W'(HDR_WORDS - 1)) && (f_len == 16'd0);
            unique case (wcnt_reg[2:0])
                3'd0:    bld_word = FRM_MAGIC;
                3'd1:    bld_word = {f_len[15:8], f_len[7:0], 8'h00, f_type};
                3'd2:    bld_word = sid_reg;
                3'd3:    bld_word = f_seq;
                default: bld_word = f_crc;
            endcase
        end
        else
        begin
            bld_vb   = (p_rem >= 16'd4) ? 3'd4 : p_rem[2:0];
            bld_last = (p_rem <= 16'd4);
            for (int j = 0; j < 4; j++)
            begin
                bld_word[8*j +: 8] = (3'(j) < bld_vb) ? raw_word[8*j +: 8] : 8'h00;
            end
        end
    end

    // State update
    always_comb
    begin
        nsid_next  = nsid_reg;
        sid_next   = sid_reg;
        seq_next   = seq_reg;
        total_next = total_reg;
        tcrc_next  = tcrc_reg;
        chunk_next = chunk_reg;
        pend_next  = pend_reg;
        begun_next = begun_reg;
        ecrc_next  = ecrc_reg;
        ecnt_next  = ecnt_reg;

        if (cmd.take)
        begin
            unique case (act_in)
                ACT_START:
                begin
                    sid_next   = nsid_reg;
                    nsid_next  = (nsid_inc == 32'd0) ? 32'd1 : nsid_inc;
                    seq_next   = '0;
                    total_next = '0;
                    tcrc_next  = '0;
                    chunk_next = '0;
                    pend_next  = '0;
                    begun_next = 1'b0;
                end
                ACT_DATA:
                begin
                    pend_next  = pend_reg + CNT_W'(1);
                    chunk_next = crc_add(chunk_reg, data_byte);
                    tcrc_next  = crc_add(tcrc_reg, data_byte);
                    total_next = total_reg + 32'd1;
                end
                ACT_END:
                begin
                    ecrc_next = '0;
                    ecnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.ecrc_step)
        begin
            ecrc_next = crc_add(ecrc_reg, ebyte);
            ecnt_next = ecnt_reg + 3'd1;
        end

        if (frame_done)
        begin
            unique case (cmd.kind)
                FK_BEGIN: begun_next = 1'b1;
                FK_DATA:
                begin
                    seq_next   = seq_reg + 32'd1;
                    pend_next  = '0;
                    chunk_next = '0;
                end
                default:
                begin
                    // end of stream or abort: drop per-stream state
                    seq_next   = '0;
                    total_next = '0;
                    tcrc_next  = '0;
                    chunk_next = '0;
                    pend_next  = '0;
                    begun_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd.emit && fire)
            wcnt_next = bld_last ? '0 : wcnt_reg + WC_W'(1);
        else
            wcnt_next = wcnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsid_reg      <= 32'd1;
            sid_reg       <= '0;
            seq_reg       <= '0;
            total_reg     <= '0;
            tcrc_reg      <= '0;
            chunk_reg     <= '0;
            pend_reg      <= '0;
            begun_reg     <= 1'b0;
            ecrc_reg      <= '0;
            ecnt_reg      <= '0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nsid_reg  <= nsid_next;
            sid_reg   <= sid_next;
            seq_reg   <= seq_next;
            total_reg <= total_next;
            tcrc_reg  <= tcrc_next;
            chunk_reg <= chunk_next;
            pend_reg  <= pend_next;
            begun_reg <= begun_next;
            ecrc_reg  <= ecrc_next;
            ecnt_reg  <= ecnt_next;
            wcnt_reg  <= wcnt_next;
            if (cmd.emit && fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && fire)
        begin
            word_reg  <= bld_word;
            vb_reg    <= bld_vb;
            flast_reg <= bld_last;
            ilast_reg <= bld_last && cmd.item_last;
        end
    end

    // Buffer: write one byte per data word, read one row ahead of the builder
    assign wr_en   = cmd.take && (act_in == ACT_DATA);
    assign wr_row  = ROW_W'(pend_reg >> 2);
    assign wr_lane = pend_reg[1:0];
    assign rd_idx  = (wcnt_next >= WC_W'(HDR_WORDS)) ? wcnt_next - WC_W'(HDR_WORDS) : '0;
    assign rd_row  = ROW_W'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_row][{wr_lane, 3'b000} +: 8] <= data_byte;
        rd_data_reg <= buf_mem[rd_row];
    end

    assign out_valid   = out_valid_reg;
    assign frame_word  = word_reg;
    assign valid_bytes = vb_reg;
    assign frame_last  = flast_reg;
    assign item_last   = ilast_reg;

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(PAYLOAD_BYTES))
        else $error("pending byte count beyond buffer size");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_done && cmd.kind == FK_DATA) |=> (pend_reg == '0))
        else $error("pending bytes left after data frame");

    a_item_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ilast_reg) |-> flast_reg)
        else $error("item end marked inside a frame");

    a_wcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.emit |-> (wcnt_reg == '0))
        else $error("word counter busy outside a frame");
`endif

endmodule

// ----- src/crc_stream_frame_packer_core.sv -----
// Top level of the stream frame packer: controller plus datapath.
// Depends on csfp_pkg, csfp_ctrl and csfp_datapath.
//
// Takes one action word at a time and emits frames as 32-bit words, first
// byte in bits 7:0, one word per cycle while out_stall is low. A start, or a
// data byte that neither opens a stream nor fills the buffer, leaves the core
// idle, so bytes stream in back to back. Frame lengths in words: begin 11,
// data 5 + ceil(n/4) for n buffered bytes, end 7, abort 5. An end action first
// runs the end-frame CRC through the byte-wide CRC unit.
// in_stall stays high from the cycle after an item that produces frames until
// its last word has entered the output register; the buffer is a row memory
// with one write port and one read port, read one row ahead of the word builder.
module crc_stream_frame_packer_core #(
    parameter int PAYLOAD_BYTES = csfp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] frame_word,
    output logic [2:0]  valid_bytes,
    output logic        frame_last,
    output logic        item_last
);
    import csfp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    csfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    csfp_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_word  (frame_word),
        .valid_bytes (valid_bytes),
        .frame_last  (frame_last),
        .item_last   (item_last)
    );

endmodule

// ----- verif/crc_stream_frame_packer_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for crc_stream_frame_packer_core: action words go in through a queued
// driver and frame words are checked as they come out, against a behavioural packer.
// Depends on csfp_pkg and the core RTL in src.
module crc_stream_frame_packer_core_test;
    import csfp_pkg::*;

    localparam int BUF_BYTES = 64;
    localparam int HDR_BYTES = HDR_WORDS * 4;
    localparam int PL_MAX    = BUF_BYTES + CTYPE_BYTES;
    localparam logic [8*CTYPE_BYTES-1:0] CT_TEXT = "text/plain;charset=utf-8";

    typedef struct packed {
        action_t    act;
        logic [7:0] dbyte;
        logic       drain;
    } act_word_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        flast;
        logic        ilast;
    } frame_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = 2'd0;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] frame_word;
    logic [2:0]  valid_bytes;
    logic        frame_last;
    logic        item_last;

    act_word_t   actions_todo[$];
    frame_word_t frame_words_due[$];
    frame_word_t item_words[$];

    // packer state
    logic [31:0] nxt_id = 32'd1;
    logic [31:0] cur_id = 32'd0;
    logic [31:0] seq_no = 32'd0;
    logic [31:0] byte_total = 32'd0;
    logic [31:0] stream_crc = 32'd0;
    logic [7:0]  chunk [0:BUF_BYTES-1];
    int          chunk_len = 0;
    logic        begun = 1'b0;
    logic [7:0]  frm_pl [0:PL_MAX-1];

    logic live = 1'b0;
    logic in_taken = 1'b0;
    logic calm = 1'b0;
    logic hold_next = 1'b0;
    int   err_count = 0;
    int   words_seen = 0;

    logic tx_busy = 1'b0;
    int   tx_gap = 0;
    int   tx_rate = 2;
    int   tx_tick = 0;
    int   rx_gap = 0;
    int   rx_rate = 2;
    int   rx_tick = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    crc_stream_frame_packer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_word  (frame_word),
        .valid_bytes (valid_bytes),
        .frame_last  (frame_last),
        .item_last   (item_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    // Lay out header plus frm_pl[0..len-1] and cut it into words
    task automatic build_frame(input logic [7:0] ftype, input logic [31:0] seqn, input int len);
        logic [7:0]  fb [0:HDR_BYTES+PL_MAX-1];
        logic [31:0] crc;
        logic [15:0] len_v;
        frame_word_t fw;
        int          total;
        crc = 32'd0;
        len_v = 16'(len);
        for (int i = 0; i < len; i++)
        begin
            crc = crc32_byte(crc, frm_pl[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            fb[i]      = FRM_MAGIC[8*i +: 8];
            fb[8 + i]  = cur_id[8*i +: 8];
            fb[12 + i] = seqn[8*i +: 8];
            fb[16 + i] = crc[8*i +: 8];
        end
        fb[4] = ftype;
        fb[5] = 8'd0;
        fb[6] = len_v[7:0];
        fb[7] = len_v[15:8];
        for (int i = 0; i < len; i++)
        begin
            fb[HDR_BYTES + i] = frm_pl[i];
        end
        total = HDR_BYTES + len;
        for (int i = 0; i < total; i += 4)
        begin
            fw = '0;
            fw.nbytes = (total - i < 4) ? 3'(total - i) : 3'd4;
            for (int j = 0; j < fw.nbytes; j++)
            begin
                fw.word[8*j +: 8] = fb[i + j];
            end
            fw.flast = (i + 4 >= total);
            item_words.push_back(fw);
        end
    endtask

    task automatic send_begin();
        for (int i = 0; i < CTYPE_BYTES; i++)
        begin
            frm_pl[i] = CT_TEXT[8*(CTYPE_BYTES-1-i) +: 8];
        end
        build_frame(FT_BEGIN, 32'd0, CTYPE_BYTES);
        begun = 1'b1;
    endtask

    task automatic flush_chunk();
        if (chunk_len != 0)
        begin
            seq_no = seq_no + 32'd1;
            for (int i = 0; i < chunk_len; i++)
            begin
                frm_pl[i] = chunk[i];
            end
            build_frame(FT_DATA, seq_no, chunk_len);
            chunk_len = 0;
        end
    endtask

    task automatic clear_stream();
        seq_no = 32'd0;
        byte_total = 32'd0;
        stream_crc = 32'd0;
        chunk_len = 0;
        begun = 1'b0;
    endtask

    // Advance the packer by one action word and queue the frame words it causes
    task automatic pack_action(input action_t act, input logic [7:0] b);
        frame_word_t fw;
        item_words.delete();
        case (act)
            ACT_START:
            begin
                cur_id = nxt_id;
                nxt_id = nxt_id + 32'd1;
                if (nxt_id == 32'd0)
                begin
                    nxt_id = 32'd1;
                end
                clear_stream();
            end
            ACT_DATA:
            begin
                if (!begun)
                begin
                    send_begin();
                end
                chunk[chunk_len] = b;
                chunk_len++;
                stream_crc = crc32_byte(stream_crc, b);
                byte_total = byte_total + 32'd1;
                if (chunk_len >= BUF_BYTES)
                begin
                    flush_chunk();
                end
            end
            ACT_END:
            begin
                if (!begun)
                begin
                    send_begin();
                end
                flush_chunk();
                for (int i = 0; i < 4; i++)
                begin
                    frm_pl[i]     = byte_total[8*i +: 8];
                    frm_pl[4 + i] = stream_crc[8*i +: 8];
                end
                build_frame(FT_END, seq_no + 32'd1, END_BYTES);
                clear_stream();
            end
            default:
            begin
                build_frame(FT_ABORT, seq_no + 32'd1, 0);
                clear_stream();
            end
        endcase
        for (int i = 0; i < item_words.size(); i++)
        begin
            fw = item_words[i];
            fw.ilast = (i == item_words.size() - 1);
            frame_words_due.push_back(fw);
        end
    endtask

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
            err_count++;
        end
    endfunction

    task automatic queue_action(input action_t a, input logic [7:0] b);
        act_word_t w;
        w.act = a;
        w.dbyte = b;
        w.drain = hold_next;
        hold_next = 1'b0;
        actions_todo.push_back(w);
    endtask

    task automatic queue_stream(input int nbytes, input logic with_start, input logic aborted);
        if (with_start)
        begin
            queue_action(ACT_START, 8'($urandom));
        end
        repeat (nbytes)
        begin
            queue_action(ACT_DATA, 8'($urandom));
        end
        queue_action(aborted ? ACT_ABORT : ACT_END, 8'($urandom));
    endtask

    // Sample both handshakes; predict accepted action words, check accepted frame words
    always @(posedge clk)
    begin
        frame_word_t fw;
        live <= rst_n;
        in_taken <= rst_n && in_valid && !in_stall;
        calm <= (actions_todo.size() <= 60);
        if (rst_n && in_valid && !in_stall)
        begin
            pack_action(action_t'(action), data_byte);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (frame_words_due.size() == 0)
            begin
                $display("%0t ns: frame word expected none, got %h", $time, frame_word);
                err_count++;
            end
            else
            begin
                fw = frame_words_due.pop_front();
                check_field("frame_word", fw.word, frame_word);
                check_field("valid_bytes", 32'(fw.nbytes), 32'(valid_bytes));
                check_field("frame_last", 32'(fw.flast), 32'(frame_last));
                check_field("item_last", 32'(fw.ilast), 32'(item_last));
            end
        end
    end

    // Sender: hold a word until taken, then move on, idle in bursts or wait for a drain
    always @(negedge clk)
    begin
        act_word_t nxt;
        logic      go;
        if (live && !(tx_busy && !in_taken))
        begin
            if (tx_busy)
            begin
                nxt = actions_todo.pop_front();
            end
            tx_tick++;
            if (tx_tick % 100 == 0)
            begin
                tx_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            end
            go = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
            end
            else if (actions_todo.size() != 0
                     && !(actions_todo[0].drain && frame_words_due.size() != 0))
            begin
                if (!calm && tx_rate != 0 && $urandom_range(0, 15) < tx_rate)
                begin
                    tx_gap = $urandom_range(0, 14);
                end
                else
                begin
                    go = 1'b1;
                end
            end
            if (go)
            begin
                nxt = actions_todo[0];
                in_valid <= 1'b1;
                action <= nxt.act;
                data_byte <= nxt.dbyte;
            end
            else
            begin
                in_valid <= 1'b0;
                action <= 2'($urandom);
                data_byte <= 8'($urandom);
            end
            tx_busy = go;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back the core up
    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 128 == 0)
        begin
            rx_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        end
        if (!hold_done && words_seen >= 200)
        begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else if (!calm && rx_rate != 0 && $urandom_range(0, 15) < rx_rate)
        begin
            rx_gap = $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int   n;
        logic drained;
        drained = 1'b0;

        // bytes ahead of any start run under stream id 0
        queue_action(ACT_DATA, 8'h00);
        queue_action(ACT_DATA, 8'hFF);
        queue_action(ACT_END, 8'hFF);
        // bytes after an end reopen the same id with a fresh begin frame
        queue_action(ACT_DATA, 8'hA5);
        queue_action(ACT_ABORT, 8'h00);
        // end with nothing begun: begin frame then an empty end
        queue_action(ACT_END, 8'h5A);
        queue_action(ACT_START, 8'hFF);
        queue_action(ACT_END, 8'h00);
        queue_action(ACT_START, 8'h00);
        queue_action(ACT_ABORT, 8'hFF);
        queue_action(ACT_ABORT, 8'h00);
        queue_action(ACT_START, 8'h12);
        queue_action(ACT_START, 8'h34);
        // exactly one payload word
        queue_action(ACT_DATA, 8'h5A);
        queue_action(ACT_DATA, 8'h3C);
        queue_action(ACT_DATA, 8'hC3);
        queue_action(ACT_DATA, 8'h81);
        queue_action(ACT_END, 8'h00);
        // abort drops the pending bytes
        queue_action(ACT_START, 8'h00);
        queue_action(ACT_DATA, 8'h7E);
        queue_action(ACT_DATA, 8'h01);
        queue_action(ACT_DATA, 8'h80);
        queue_action(ACT_ABORT, 8'hFF);
        queue_action(ACT_DATA, 8'hFF);
        queue_action(ACT_END, 8'hFF);

        // full buffer flushed just before the end, then a partial one aborted
        hold_next = 1'b1;
        queue_stream(64, 1'b1, 1'b0);
        queue_stream(70, 1'b1, 1'b1);
        while (actions_todo.size() < 330)
        begin
            if (!drained && actions_todo.size() > 220)
            begin
                hold_next = 1'b1;
                drained = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 5))
                    0: n = $urandom_range(0, 3);
                    1: n = $urandom_range(4, 20);
                    2: n = $urandom_range(60, 68);
                    3: n = 128;
                    default: n = $urandom_range(1, 40);
                endcase
                // keep the last stream from running far past the item budget
                if (n > 330 - actions_todo.size())
                begin
                    n = 330 - actions_todo.size();
                end
                queue_stream(n, $urandom_range(0, 9) != 0, $urandom_range(0, 5) == 0);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_action(action_t'($urandom_range(0, 3)), 8'($urandom));
                end
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (actions_todo.size() != 0 || frame_words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (err_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule
